// ----- sv/lzfg_pkg.sv -----
`timescale 1ns / 1ps

package lzfg_pkg;

    localparam int BYTE_W      = 8;
    localparam int CODE_W      = 16;
    localparam int DIST_W      = 12;
    localparam int LEN_W       = 4;
    localparam int RUN_W       = 5;
    localparam int MIN_RUN     = 3;
    localparam int GROUP_FLAGS = 8;
    localparam int FLAG_CNT_W  = 4;
    localparam int Q_DEPTH     = 4;
    localparam int Q_AW        = 2;

    // one unit of work for the copy engine
    typedef struct packed {
        logic              is_copy;
        logic [CODE_W-1:0] code;    // literal in the low byte, or the whole token
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_EMIT
    } t_back_state;

endpackage

// ----- sv/lz77_flag_group_decompressor_top.sv -----
`timescale 1ns / 1ps

// channel   direction  tdata                tlast
// s         in         [7:0] in_byte        block_end
// m         out        [7:0] out_byte       run_last
//
// the parser takes one compressed byte per cycle while its command queue has room
// a literal leaves the copy engine as it is popped, a back-reference of length L holds
// the engine until its last byte: each copied byte is a registered history read, then a write
// history is a 4096-byte ram; bytes not yet written since reset read as zero by a
// wrap mark and the write position, so there is no clearing pass after reset
// reset is synchronous, active low; a stalled output holds the engine, the queue
// then fills and the input side stalls in turn

module lz77_flag_group_decompressor_top #(
    parameter int WINDOW_DEPTH = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  logic       i_s_tlast,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tlast
);
    import lzfg_pkg::*;

    t_q_status q_stat;
    t_cmd      push_cmd;
    t_cmd      pop_cmd;
    logic      push;
    logic      pop;

    lzfg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    lzfg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (pop_cmd),
        .o_stat  (q_stat)
    );

    lzfg_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (pop_cmd),
        .i_q_stat   (q_stat),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// ----- sv/lzfg_ram.sv -----
`timescale 1ns / 1ps

module lzfg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/lzfg_front.sv -----
`timescale 1ns / 1ps

module lzfg_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [7:0]          i_s_tdata,
    input  logic                i_s_tlast,
    input  lzfg_pkg::t_q_status i_q_stat,
    output logic                o_push,
    output lzfg_pkg::t_cmd      o_cmd
);
    import lzfg_pkg::*;

    logic [BYTE_W-1:0]     r_flag_bits, n_flag_bits;
    logic [FLAG_CNT_W-1:0] r_flags_left, n_flags_left;
    logic [BYTE_W-1:0]     r_tok_low, n_tok_low;
    logic                  r_tok_pend, n_tok_pend;
    logic                  accept;

    assign o_s_tready = !i_q_stat.full;
    assign accept     = i_s_tvalid && !i_q_stat.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag_bits  <= '0;
            r_flags_left <= '0;
            r_tok_low    <= '0;
            r_tok_pend   <= 1'b0;
        end else begin
            r_flag_bits  <= n_flag_bits;
            r_flags_left <= n_flags_left;
            r_tok_low    <= n_tok_low;
            r_tok_pend   <= n_tok_pend;
        end
    end

    always_comb begin
        n_flag_bits  = r_flag_bits;
        n_flags_left = r_flags_left;
        n_tok_low    = r_tok_low;
        n_tok_pend   = r_tok_pend;
        o_push       = 1'b0;
        o_cmd        = '{is_copy: 1'b0, code: {{(CODE_W-BYTE_W){1'b0}}, i_s_tdata}};
        if (accept) begin
            priority if (r_flags_left == '0) begin
                // control byte opens a new flag group
                n_flag_bits  = i_s_tdata;
                n_flags_left = i_s_tlast ? '0 : FLAG_CNT_W'(GROUP_FLAGS);
                n_tok_pend   = 1'b0;
            end else if (r_tok_pend) begin
                o_push       = 1'b1;
                o_cmd        = '{is_copy: 1'b1, code: {i_s_tdata, r_tok_low}};
                n_tok_pend   = 1'b0;
                n_flag_bits  = r_flag_bits >> 1;
                n_flags_left = i_s_tlast ? '0 : r_flags_left - 1'b1;
            end else if (r_flag_bits[0]) begin
                // token split by a block end is dropped
                if (i_s_tlast) begin
                    n_flags_left = '0;
                    n_tok_pend   = 1'b0;
                end else begin
                    n_tok_low  = i_s_tdata;
                    n_tok_pend = 1'b1;
                end
            end else begin
                o_push       = 1'b1;
                n_flag_bits  = r_flag_bits >> 1;
                n_flags_left = i_s_tlast ? '0 : r_flags_left - 1'b1;
            end
        end
    end

endmodule

// ----- sv/lzfg_queue.sv -----
`timescale 1ns / 1ps

module lzfg_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  lzfg_pkg::t_cmd      i_cmd,
    input  logic                i_pop,
    output lzfg_pkg::t_cmd      o_cmd,
    output lzfg_pkg::t_q_status o_stat
);
    import lzfg_pkg::*;

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wptr;
    logic [Q_AW-1:0] r_rptr;
    logic [Q_AW:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= r_count + (Q_AW+1)'(i_push) - (Q_AW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    assign o_cmd        = r_mem[r_rptr];
    assign o_stat.full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

// ----- sv/lzfg_back.sv -----
`timescale 1ns / 1ps

module lzfg_back #(
    parameter int WINDOW_DEPTH = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lzfg_pkg::t_cmd      i_cmd,
    input  lzfg_pkg::t_q_status i_q_stat,
    output logic                o_pop,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [7:0]          o_m_tdata,
    output logic                o_m_tlast
);
    import lzfg_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);

    t_back_state       r_state, n_state;
    logic [AW-1:0]     r_wp, n_wp;
    logic              r_wrapped, n_wrapped;
    logic [RUN_W-1:0]  r_left, n_left;
    logic [DIST_W-1:0] r_dist, n_dist;
    logic              r_src_ok, n_src_ok;
    logic              r_out_valid, n_out_valid;
    logic [BYTE_W-1:0] r_out_data, n_out_data;
    logic              r_out_last, n_out_last;

    logic              out_free;
    logic [AW-1:0]     src;
    logic              rd_en;
    logic [BYTE_W-1:0] rd_data;
    logic              emit;
    logic [BYTE_W-1:0] emit_byte;
    logic              emit_last;

    lzfg_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (emit),
        .i_waddr (r_wp),
        .i_wdata (emit_byte),
        .i_re    (rd_en),
        .i_raddr (src),
        .o_rdata (rd_data)
    );

    assign out_free = !r_out_valid || i_m_tready;
    assign src      = r_wp - AW'(r_dist) - AW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_wp        <= '0;
            r_wrapped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_wrapped   <= n_wrapped;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left     <= n_left;
        r_dist     <= n_dist;
        r_src_ok   <= n_src_ok;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    always_comb begin
        n_state     = r_state;
        n_left      = r_left;
        n_dist      = r_dist;
        n_src_ok    = r_src_ok;
        o_pop       = 1'b0;
        rd_en       = 1'b0;
        emit        = 1'b0;
        emit_byte   = i_cmd.code[BYTE_W-1:0];
        emit_last   = 1'b1;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_stat.empty && out_free) begin
                    o_pop = 1'b1;
                    if (i_cmd.is_copy) begin
                        n_left  = RUN_W'(MIN_RUN) + RUN_W'(i_cmd.code[CODE_W-1 -: LEN_W]);
                        n_dist  = i_cmd.code[DIST_W-1:0];
                        n_state = BK_READ;
                    end else begin
                        emit = 1'b1;
                    end
                end
            end
            BK_READ: begin
                rd_en = 1'b1;
                // slots never written since reset still read as zero
                n_src_ok = r_wrapped || (src < r_wp);
                n_state  = BK_EMIT;
            end
            BK_EMIT: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_byte = r_src_ok ? rd_data : '0;
                    emit_last = (r_left == RUN_W'(1));
                    n_left    = r_left - 1'b1;
                    n_state   = emit_last ? BK_IDLE : BK_READ;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        n_wp        = r_wp;
        n_wrapped   = r_wrapped;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        if (emit) begin
            n_wp        = r_wp + 1'b1;
            n_wrapped   = r_wrapped || (r_wp == AW'(WINDOW_DEPTH - 1));
            n_out_valid = 1'b1;
            n_out_data  = emit_byte;
            n_out_last  = emit_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule

// ----- sv/lzfg_checker.sv -----
`timescale 1ns / 1ps

module lzfg_props (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       o_s_tready,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic       o_m_tlast
);

    // inputs taken since reset, saturating at two
    logic [1:0] r_in_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_cnt <= '0;
        end else if (i_s_tvalid && o_s_tready && r_in_cnt != 2'd2) begin
            r_in_cnt <= r_in_cnt + 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output transaction changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // a control byte and at least one more byte precede any decompressed byte
    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> r_in_cnt == 2'd2)
        else $error("output before any literal or token was taken");

endmodule

bind lz77_flag_group_decompressor_top lzfg_props u_lzfg_props (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
